// ===== src/tpch_pkg.sv =====
package tpch_pkg;

  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned LOC_W = 37;
  localparam logic signed [31:0] QUAT_ONE = 32'sd1073741824;
  localparam logic [22:0] EDGE_MIN_SQ = 23'd966368;
  localparam logic [30:0] HEIGHT_RESET = 31'd13107;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_TEST   = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    VERDICT_OK     = 2'd0,
    VERDICT_HEIGHT = 2'd1,
    VERDICT_HULL   = 2'd2
  } verdict_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_POS_X  = 3'd0,
    REG_POS_Y  = 3'd1,
    REG_POS_Z  = 3'd2,
    REG_QUAT_W = 3'd3,
    REG_QUAT_X = 3'd4,
    REG_QUAT_Y = 3'd5,
    REG_QUAT_Z = 3'd6,
    REG_HEIGHT = 3'd7
  } reg_index_t;

  typedef enum logic [2:0] {
    XF_IDLE,
    XF_QUAT,
    XF_ROT,
    XF_LOC,
    XF_SUM,
    XF_DONE
  } xf_state_t;

  typedef enum logic [1:0] {
    TOP_IDLE,
    TOP_XFORM,
    TOP_CHECK,
    TOP_EDGE
  } top_state_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] quat_w;
    logic signed [31:0] quat_x;
    logic signed [31:0] quat_y;
    logic signed [31:0] quat_z;
  } pose_t;

  typedef struct packed {
    logic                    done;
    logic signed [LOC_W-1:0] x;
    logic signed [LOC_W-1:0] y;
    logic signed [LOC_W-1:0] z;
  } loc_t;

  function automatic logic signed [31:0] sat32(input logic signed [37:0] v);
    if (v > 38'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -38'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return v[31:0];
    end
  endfunction

endpackage

// ===== src/tpch_xform.sv =====
module tpch_xform (
  input  logic                clk,
  input  logic                rst,
  input  logic                go,
  input  tpch_pkg::pose_t     pose,
  input  logic signed [31:0]  coord_x,
  input  logic signed [31:0]  coord_y,
  input  logic signed [31:0]  coord_z,
  output tpch_pkg::loc_t      loc
);

  tpch_pkg::xf_state_t state, state_next;
  logic [3:0]          step;
  logic [1:0]          li, lk;
  logic signed [63:0]  prods [9];
  logic signed [32:0]  rot [9];
  logic signed [35:0]  terms [9];
  logic signed [31:0]  d [3];
  logic signed [31:0]  qw, qx, qy, qz;
  logic signed [32:0]  mul_a, mul_b;
  logic signed [65:0]  mul_p;
  logic signed [tpch_pkg::LOC_W-1:0] lx, ly, lz;

  function automatic logic signed [31:0] clamp_q(input logic signed [31:0] v);
    if (v > tpch_pkg::QUAT_ONE) begin
      return tpch_pkg::QUAT_ONE;
    end else if (v < -tpch_pkg::QUAT_ONE) begin
      return -tpch_pkg::QUAT_ONE;
    end else begin
      return v;
    end
  endfunction

  function automatic logic signed [32:0] to_q30(input logic signed [63:0] v);
    logic signed [63:0] t;
    t = (v + 64'sd536870912) >>> 30;
    if (t > 64'sd2147483648) begin
      return 33'sd2147483648;
    end else if (t < -64'sd2147483648) begin
      return -33'sd2147483648;
    end else begin
      return t[32:0];
    end
  endfunction

  assign qw = clamp_q(pose.quat_w);
  assign qx = clamp_q(pose.quat_x);
  assign qy = clamp_q(pose.quat_y);
  assign qz = clamp_q(pose.quat_z);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state == tpch_pkg::XF_LOC) begin
      mul_a = rot[4'(li) * 4'd3 + 4'(lk)];
      mul_b = 33'(d[li]);
    end else begin
      unique case (step)
        4'd0: begin mul_a = 33'(qx); mul_b = 33'(qx); end
        4'd1: begin mul_a = 33'(qy); mul_b = 33'(qy); end
        4'd2: begin mul_a = 33'(qz); mul_b = 33'(qz); end
        4'd3: begin mul_a = 33'(qx); mul_b = 33'(qy); end
        4'd4: begin mul_a = 33'(qx); mul_b = 33'(qz); end
        4'd5: begin mul_a = 33'(qy); mul_b = 33'(qz); end
        4'd6: begin mul_a = 33'(qw); mul_b = 33'(qx); end
        4'd7: begin mul_a = 33'(qw); mul_b = 33'(qy); end
        4'd8: begin mul_a = 33'(qw); mul_b = 33'(qz); end
        default: begin mul_a = '0; mul_b = '0; end
      endcase
    end
  end

  assign mul_p = mul_a * mul_b;

  always_comb begin
    state_next = state;
    unique case (state)
      tpch_pkg::XF_IDLE: if (go) state_next = tpch_pkg::XF_QUAT;
      tpch_pkg::XF_QUAT: if (step == 4'd8) state_next = tpch_pkg::XF_ROT;
      tpch_pkg::XF_ROT:  state_next = tpch_pkg::XF_LOC;
      tpch_pkg::XF_LOC:  if (step == 4'd8) state_next = tpch_pkg::XF_SUM;
      tpch_pkg::XF_SUM:  state_next = tpch_pkg::XF_DONE;
      tpch_pkg::XF_DONE: state_next = tpch_pkg::XF_IDLE;
      default:           state_next = tpch_pkg::XF_IDLE;
    endcase
  end

  always_comb begin
    loc.done = (state == tpch_pkg::XF_DONE);
    loc.x = lx;
    loc.y = ly;
    loc.z = lz;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tpch_pkg::XF_IDLE;
      step <= '0;
      li <= '0;
      lk <= '0;
    end else begin
      state <= state_next;
      if (state == tpch_pkg::XF_QUAT || state == tpch_pkg::XF_LOC) begin
        step <= (step == 4'd8) ? 4'd0 : step + 4'd1;
      end else begin
        step <= '0;
      end
      if (state == tpch_pkg::XF_LOC) begin
        if (li == 2'd2) begin
          li <= '0;
          lk <= lk + 2'd1;
        end else begin
          li <= li + 2'd1;
        end
      end else begin
        li <= '0;
        lk <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == tpch_pkg::XF_IDLE && go) begin
      d[0] <= tpch_pkg::sat32(38'(coord_x) - 38'(pose.pos_x));
      d[1] <= tpch_pkg::sat32(38'(coord_y) - 38'(pose.pos_y));
      d[2] <= tpch_pkg::sat32(38'(coord_z) - 38'(pose.pos_z));
    end
    if (state == tpch_pkg::XF_QUAT) begin
      prods[step] <= mul_p[63:0];
    end
    if (state == tpch_pkg::XF_ROT) begin
      rot[0] <= to_q30((64'sd1 <<< 60) - 64'sd2 * (prods[1] + prods[2]));
      rot[1] <= to_q30(64'sd2 * (prods[3] - prods[8]));
      rot[2] <= to_q30(64'sd2 * (prods[4] + prods[7]));
      rot[3] <= to_q30(64'sd2 * (prods[3] + prods[8]));
      rot[4] <= to_q30((64'sd1 <<< 60) - 64'sd2 * (prods[0] + prods[2]));
      rot[5] <= to_q30(64'sd2 * (prods[5] - prods[6]));
      rot[6] <= to_q30(64'sd2 * (prods[4] - prods[7]));
      rot[7] <= to_q30(64'sd2 * (prods[5] + prods[6]));
      rot[8] <= to_q30((64'sd1 <<< 60) - 64'sd2 * (prods[0] + prods[1]));
    end
    if (state == tpch_pkg::XF_LOC) begin
      terms[step] <= mul_p[65:30];
    end
    if (state == tpch_pkg::XF_SUM) begin
      lx <= 37'(terms[0]) + 37'(terms[1]) + 37'(terms[2]);
      ly <= 37'(terms[3]) + 37'(terms[4]) + 37'(terms[5]);
      lz <= 37'(terms[6]) + 37'(terms[7]) + 37'(terms[8]);
    end
  end

endmodule

// ===== src/tabletop_point_in_convex_hull_unit.sv =====
// Point-in-convex-hull tester for a tabletop.
// Command channel: start with command, coord_x, coord_y, coord_z is taken at a
// rising edge with start high and busy low. Clear and append complete in that
// edge and leave busy low. A test raises busy until its result is out.
// Result channel: res_valid is high for one cycle with inside_res and verdict;
// the receiver cannot stall, so the result is simply presented and dropped.
// Configuration: cfg_we, cfg_index, cfg_data write one register per edge;
// the user must write only while busy is low, which the block does not enforce.
// A test runs through the frame transform (one shared 33x33 multiplier: nine
// quaternion products, a matrix step, nine matrix products, a sum step and
// a hand-off step), the height check, then, with n stored vertices, streams
// the hull through a single read port of the vertex memories, one edge per
// cycle. Busy drops in the cycle in which res_valid is high; a height reject
// or an empty hull ends the test at the height check, without streaming.
// The next command can be taken in the result cycle.
// Reset: registers return to their defaults and the hull count to zero; the
// vertex memories are not cleared and need no clearing pass.
module tabletop_point_in_convex_hull_unit #(
  parameter int unsigned MAX_VERTICES = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          command,
  input  logic signed [31:0]                  coord_x,
  input  logic signed [31:0]                  coord_y,
  input  logic signed [31:0]                  coord_z,
  output logic                                res_valid,
  output logic                                inside_res,
  output logic [1:0]                          verdict,
  input  logic                                cfg_we,
  input  logic [tpch_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [31:0]                         cfg_data
);

  localparam int unsigned AW = $clog2(MAX_VERTICES);
  localparam int unsigned CW = $clog2(MAX_VERTICES + 1);

  tpch_pkg::top_state_t state, state_next;
  tpch_pkg::pose_t      pose;
  tpch_pkg::loc_t       loc;
  logic [30:0]          height_limit;
  logic [CW-1:0]        hull_count;
  logic signed [31:0]   hull_x [MAX_VERTICES];
  logic signed [31:0]   hull_y [MAX_VERTICES];
  logic signed [31:0]   mx_q, my_q;
  logic                 accept, xf_go, height_bad, iss_en;
  logic [CW-1:0]        iss;
  logic                 iss_done;
  logic [AW-1:0]        rd_addr;
  logic                 rd_v, rd_first, rd_last;
  logic signed [31:0]   prev_x, prev_y;
  logic                 s2_v, s2_last, s2_small;
  logic signed [10:0]   s2_ex, s2_ey;
  logic signed [31:0]   s2_ax, s2_ay, s2_bx, s2_by;
  logic                 s3_v, s3_last, s3_short;
  logic signed [63:0]   s3_p1, s3_p2;
  logic                 first_e, ref_pos, fail, mismatch;
  logic signed [32:0]   ex, ey;
  logic [22:0]          sq_sum;

  assign accept = start && !busy;

  tpch_xform u_xform (
    .clk     (clk),
    .rst     (rst),
    .go      (xf_go),
    .pose    (pose),
    .coord_x (coord_x),
    .coord_y (coord_y),
    .coord_z (coord_z),
    .loc     (loc)
  );

  assign height_bad = (loc.z < 0) || (loc.z > $signed({6'd0, height_limit}));

  always_comb begin
    state_next = state;
    unique case (state)
      tpch_pkg::TOP_IDLE: begin
        if (accept && command == tpch_pkg::CMD_TEST) state_next = tpch_pkg::TOP_XFORM;
      end
      tpch_pkg::TOP_XFORM: if (loc.done) state_next = tpch_pkg::TOP_CHECK;
      tpch_pkg::TOP_CHECK: begin
        if (height_bad || hull_count == '0) begin
          state_next = tpch_pkg::TOP_IDLE;
        end else begin
          state_next = tpch_pkg::TOP_EDGE;
        end
      end
      tpch_pkg::TOP_EDGE: if (s3_v && s3_last) state_next = tpch_pkg::TOP_IDLE;
      default: state_next = tpch_pkg::TOP_IDLE;
    endcase
  end

  always_comb begin
    busy = (state != tpch_pkg::TOP_IDLE);
    xf_go = (state == tpch_pkg::TOP_IDLE) && accept && (command == tpch_pkg::CMD_TEST);
    iss_en = (state == tpch_pkg::TOP_EDGE) && !iss_done;
    rd_addr = (iss == hull_count) ? '0 : iss[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tpch_pkg::TOP_IDLE;
      hull_count <= '0;
      pose.pos_x <= '0;
      pose.pos_y <= '0;
      pose.pos_z <= '0;
      pose.quat_w <= tpch_pkg::QUAT_ONE;
      pose.quat_x <= '0;
      pose.quat_y <= '0;
      pose.quat_z <= '0;
      height_limit <= tpch_pkg::HEIGHT_RESET;
      res_valid <= 1'b0;
      rd_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
      iss <= '0;
      iss_done <= 1'b0;
    end else begin
      state <= state_next;
      res_valid <= 1'b0;
      if (cfg_we) begin
        unique case (tpch_pkg::reg_index_t'(cfg_index))
          tpch_pkg::REG_POS_X:  pose.pos_x <= cfg_data;
          tpch_pkg::REG_POS_Y:  pose.pos_y <= cfg_data;
          tpch_pkg::REG_POS_Z:  pose.pos_z <= cfg_data;
          tpch_pkg::REG_QUAT_W: pose.quat_w <= cfg_data;
          tpch_pkg::REG_QUAT_X: pose.quat_x <= cfg_data;
          tpch_pkg::REG_QUAT_Y: pose.quat_y <= cfg_data;
          tpch_pkg::REG_QUAT_Z: pose.quat_z <= cfg_data;
          tpch_pkg::REG_HEIGHT: height_limit <= cfg_data[30:0];
          default: ;
        endcase
      end
      if (state == tpch_pkg::TOP_IDLE && accept) begin
        if (command == tpch_pkg::CMD_CLEAR) begin
          hull_count <= '0;
        end else if (command == tpch_pkg::CMD_APPEND && hull_count < CW'(MAX_VERTICES)) begin
          hull_count <= hull_count + 1'b1;
        end
      end
      if (state == tpch_pkg::TOP_CHECK) begin
        iss <= '0;
        iss_done <= 1'b0;
        if (height_bad) begin
          res_valid <= 1'b1;
          verdict <= tpch_pkg::VERDICT_HEIGHT;
          inside_res <= 1'b0;
        end else if (hull_count == '0) begin
          res_valid <= 1'b1;
          verdict <= tpch_pkg::VERDICT_OK;
          inside_res <= 1'b1;
        end
      end
      if (iss_en) begin
        iss <= iss + 1'b1;
        if (iss == hull_count) iss_done <= 1'b1;
      end
      rd_v <= iss_en;
      s2_v <= rd_v && !rd_first;
      s3_v <= s2_v;
      if (state == tpch_pkg::TOP_EDGE && s3_v && s3_last) begin
        res_valid <= 1'b1;
        verdict <= (fail || mismatch) ? tpch_pkg::VERDICT_HULL : tpch_pkg::VERDICT_OK;
        inside_res <= !(fail || mismatch);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == tpch_pkg::TOP_IDLE && accept && command == tpch_pkg::CMD_APPEND
        && hull_count < CW'(MAX_VERTICES)) begin
      hull_x[hull_count[AW-1:0]] <= coord_x;
      hull_y[hull_count[AW-1:0]] <= coord_y;
    end
    if (iss_en) begin
      mx_q <= hull_x[rd_addr];
      my_q <= hull_y[rd_addr];
    end
  end

  assign ex = 33'(mx_q) - 33'(prev_x);
  assign ey = 33'(my_q) - 33'(prev_y);
  assign sq_sum = 23'(s2_ex * s2_ex) + 23'(s2_ey * s2_ey);
  assign mismatch = s3_v && !s3_short && !first_e && ((s3_p1 > s3_p2) != ref_pos);

  always_ff @(posedge clk) begin
    rd_first <= (iss == '0);
    rd_last <= (iss == hull_count);
    if (rd_v) begin
      prev_x <= mx_q;
      prev_y <= my_q;
      s2_last <= rd_last;
      s2_small <= (ex > -33'sd1024) && (ex < 33'sd1024) && (ey > -33'sd1024) && (ey < 33'sd1024);
      s2_ex <= ex[10:0];
      s2_ey <= ey[10:0];
      s2_ax <= tpch_pkg::sat32(38'(prev_x) - 38'(loc.x));
      s2_ay <= tpch_pkg::sat32(38'(prev_y) - 38'(loc.y));
      s2_bx <= tpch_pkg::sat32(38'(mx_q) - 38'(loc.x));
      s2_by <= tpch_pkg::sat32(38'(my_q) - 38'(loc.y));
    end
    if (s2_v) begin
      s3_last <= s2_last;
      s3_short <= s2_small && (sq_sum < tpch_pkg::EDGE_MIN_SQ);
      s3_p1 <= s2_bx * s2_ay;
      s3_p2 <= s2_ax * s2_by;
    end
    if (state == tpch_pkg::TOP_CHECK) begin
      first_e <= 1'b1;
      fail <= 1'b0;
    end else if (s3_v && !s3_short) begin
      if (first_e) begin
        ref_pos <= (s3_p1 > s3_p2);
        first_e <= 1'b0;
      end else if (mismatch) begin
        fail <= 1'b1;
      end
    end
  end

endmodule

// ===== tb/tpch_checker.sv =====
module tpch_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              busy,
  input  logic [1:0]        command,
  input  logic signed [31:0] coord_x,
  input  logic signed [31:0] coord_y,
  input  logic signed [31:0] coord_z,
  input  logic              res_valid,
  input  logic              inside_res,
  input  logic [1:0]        verdict,
  input  logic              cfg_we,
  input  logic [tpch_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [31:0]       cfg_data,
  output int                errors,
  output int                pending,
  output int                n_results
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NVERT = 32;
  localparam longint I32_LO = -64'sd2147483648;
  localparam longint I32_HI = 64'sd2147483647;

  longint vx [NVERT];
  longint vy [NVERT];
  int vcount;
  longint tx, ty, tz, qw, qx, qy, qz, hmax;
  tpch_pkg::verdict_t verdict_q[$];

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint rot_entry(longint q60);
    return clip((q60 + (longint'(1) <<< 29)) >>> 30, -(longint'(1) <<< 31),
                longint'(1) <<< 31);
  endfunction

  function automatic bit within_hull(longint ox, longint oy);
    bit first, ref_pos, pos;
    int k;
    longint ex, ey, ax, ay, bx, by;
    first = 1;
    ref_pos = 0;
    for (int j = 0; j < vcount; j++) begin
      k = (j + 1 == vcount) ? 0 : j + 1;
      ex = vx[k] - vx[j];
      ey = vy[k] - vy[j];
      if (ex > -1024 && ex < 1024 && ey > -1024 && ey < 1024 &&
          ex * ex + ey * ey < 966368) continue;
      ax = clip(vx[j] - ox, I32_LO, I32_HI);
      ay = clip(vy[j] - oy, I32_LO, I32_HI);
      bx = clip(vx[k] - ox, I32_LO, I32_HI);
      by = clip(vy[k] - oy, I32_LO, I32_HI);
      pos = (bx * ay) > (ax * by);
      if (first) begin
        ref_pos = pos;
        first = 0;
      end else if (pos != ref_pos) begin
        return 0;
      end
    end
    return 1;
  endfunction

  function automatic tpch_pkg::verdict_t classify_point(longint cx, longint cy, longint cz);
    longint w, x, y, z, one60;
    longint r [3][3];
    longint d [3];
    longint lc [3];
    w = clip(qw, -64'sd1073741824, 64'sd1073741824);
    x = clip(qx, -64'sd1073741824, 64'sd1073741824);
    y = clip(qy, -64'sd1073741824, 64'sd1073741824);
    z = clip(qz, -64'sd1073741824, 64'sd1073741824);
    one60 = longint'(1) <<< 60;
    r[0][0] = rot_entry(one60 - 2 * (y * y + z * z));
    r[0][1] = rot_entry(2 * (x * y - z * w));
    r[0][2] = rot_entry(2 * (x * z + y * w));
    r[1][0] = rot_entry(2 * (x * y + z * w));
    r[1][1] = rot_entry(one60 - 2 * (x * x + z * z));
    r[1][2] = rot_entry(2 * (y * z - x * w));
    r[2][0] = rot_entry(2 * (x * z - y * w));
    r[2][1] = rot_entry(2 * (y * z + x * w));
    r[2][2] = rot_entry(one60 - 2 * (x * x + y * y));
    d[0] = clip(cx - tx, I32_LO, I32_HI);
    d[1] = clip(cy - ty, I32_LO, I32_HI);
    d[2] = clip(cz - tz, I32_LO, I32_HI);
    for (int k = 0; k < 3; k++) begin
      lc[k] = 0;
      for (int i = 0; i < 3; i++) lc[k] += (r[i][k] * d[i]) >>> 30;
    end
    if (lc[2] < 0 || lc[2] > hmax) return tpch_pkg::VERDICT_HEIGHT;
    if (!within_hull(lc[0], lc[1])) return tpch_pkg::VERDICT_HULL;
    return tpch_pkg::VERDICT_OK;
  endfunction

  always @(posedge clk) begin
    tpch_pkg::verdict_t exp_v;
    if (rst) begin
      vcount = 0;
      tx = 0; ty = 0; tz = 0;
      qw = 64'sd1073741824; qx = 0; qy = 0; qz = 0;
      hmax = 13107;
      errors = 0;
      n_results = 0;
      verdict_q.delete();
    end else begin
      if (res_valid) begin
        n_results++;
        if (verdict_q.size() == 0) begin
          $error("result beat with no test pending");
          errors++;
        end else begin
          exp_v = verdict_q.pop_front();
          if (verdict !== exp_v) begin
            $error("verdict: expected %0d, actual %0d", exp_v, verdict);
            errors++;
          end
          if (inside_res !== (exp_v == tpch_pkg::VERDICT_OK)) begin
            $error("inside_res: expected %0d, actual %0d",
                   exp_v == tpch_pkg::VERDICT_OK, inside_res);
            errors++;
          end
        end
      end
      if (cfg_we) begin
        case (tpch_pkg::reg_index_t'(cfg_index))
          tpch_pkg::REG_POS_X:  tx = longint'($signed(cfg_data));
          tpch_pkg::REG_POS_Y:  ty = longint'($signed(cfg_data));
          tpch_pkg::REG_POS_Z:  tz = longint'($signed(cfg_data));
          tpch_pkg::REG_QUAT_W: qw = longint'($signed(cfg_data));
          tpch_pkg::REG_QUAT_X: qx = longint'($signed(cfg_data));
          tpch_pkg::REG_QUAT_Y: qy = longint'($signed(cfg_data));
          tpch_pkg::REG_QUAT_Z: qz = longint'($signed(cfg_data));
          tpch_pkg::REG_HEIGHT: hmax = longint'(cfg_data[30:0]);
          default: ;
        endcase
      end
      if (start && !busy) begin
        case (tpch_pkg::cmd_t'(command))
          tpch_pkg::CMD_CLEAR: vcount = 0;
          tpch_pkg::CMD_APPEND: begin
            if (vcount < NVERT) begin
              vx[vcount] = longint'(coord_x);
              vy[vcount] = longint'(coord_y);
              vcount++;
            end
          end
          tpch_pkg::CMD_TEST:
            verdict_q.insert(verdict_q.size(), classify_point(coord_x, coord_y, coord_z));
          default: ;
        endcase
      end
    end
    pending = verdict_q.size();
  end
endmodule

// ===== tb/tb_tabletop_point_in_convex_hull_unit.sv =====
module tb_tabletop_point_in_convex_hull_unit;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic busy;
  logic [1:0] command = tpch_pkg::CMD_NONE;
  logic signed [31:0] coord_x = 0, coord_y = 0, coord_z = 0;
  logic res_valid, inside_res;
  logic [1:0] verdict;
  logic cfg_we = 0;
  logic [tpch_pkg::CFG_INDEX_W-1:0] cfg_index = tpch_pkg::REG_POS_X;
  logic [31:0] cfg_data = 0;
  int errors, pending, n_results;
  int n_beats, n_settings;
  bit burst;
  real ang_c, ang_s, pzoff;
  longint pxo, pyo, pzo;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  tabletop_point_in_convex_hull_unit uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .command(command),
    .coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z),
    .res_valid(res_valid), .inside_res(inside_res), .verdict(verdict),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  tpch_checker chk (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .command(command),
    .coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z),
    .res_valid(res_valid), .inside_res(inside_res), .verdict(verdict),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending(pending), .n_results(n_results)
  );

  function automatic logic [31:0] q16(real r);
    return 32'($rtoi(r * 65536.0));
  endfunction

  task automatic send(tpch_pkg::cmd_t c, logic [31:0] x, logic [31:0] y, logic [31:0] z);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      start <= 0;
      repeat (gap) @(negedge clk);
    end
    while (busy) @(negedge clk);
    start <= 1;
    command <= c;
    coord_x <= x;
    coord_y <= y;
    coord_z <= z;
    @(negedge clk);
    n_beats++;
    if (n_beats % 97 == 0) burst = !burst;
  endtask

  task automatic drain();
    start <= 0;
    @(negedge clk);
    while (pending != 0 || busy) @(negedge clk);
    repeat (70) @(negedge clk);
  endtask

  task automatic write_reg(tpch_pkg::reg_index_t idx, logic [31:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
  endtask

  task automatic set_pose(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                          logic [31:0] w, logic [31:0] x, logic [31:0] y,
                          logic [31:0] z, logic [31:0] h);
    drain();
    write_reg(tpch_pkg::REG_POS_X, px);
    write_reg(tpch_pkg::REG_POS_Y, py);
    write_reg(tpch_pkg::REG_POS_Z, pz);
    write_reg(tpch_pkg::REG_QUAT_W, w);
    write_reg(tpch_pkg::REG_QUAT_X, x);
    write_reg(tpch_pkg::REG_QUAT_Y, y);
    write_reg(tpch_pkg::REG_QUAT_Z, z);
    write_reg(tpch_pkg::REG_HEIGHT, h);
    cfg_we <= 0;
    n_settings++;
    pxo = $signed(px);
    pyo = $signed(py);
    pzo = $signed(pz);
  endtask

  task automatic load_polygon(int n, real radius, bit with_dups);
    real a, step;
    send(tpch_pkg::CMD_CLEAR, $urandom, $urandom, $urandom);
    step = 6.2831853 / n;
    a = $urandom_range(0, 999) / 1000.0;
    for (int i = 0; i < n; i++) begin
      send(tpch_pkg::CMD_APPEND, q16(radius * $cos(a)), q16(radius * $sin(a)), $urandom);
      if (with_dups && $urandom_range(0, 3) == 0)
        send(tpch_pkg::CMD_APPEND, q16(radius * $cos(a) + 0.005), q16(radius * $sin(a)),
             $urandom);
      a += step * (0.6 + $urandom_range(0, 80) / 100.0) * (n / (n + 0.5));
    end
  endtask

  task automatic probe(real span);
    real lx, ly, lz;
    lx = ($urandom_range(0, 2000) / 1000.0 - 1.0) * span;
    ly = ($urandom_range(0, 2000) / 1000.0 - 1.0) * span;
    lz = $urandom_range(0, 300) / 1000.0 - 0.05;
    send(tpch_pkg::CMD_TEST, q16(ang_c * lx - ang_s * ly + pxo / 65536.0),
         q16(ang_s * lx + ang_c * ly + pyo / 65536.0), q16(lz + pzoff + pzo / 65536.0));
  endtask

  initial begin
    #20_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    real ang, rad;
    int n;
    n_beats = 0;
    n_settings = 0;
    burst = 0;
    ang_c = 1.0;
    ang_s = 0.0;
    pzoff = 0.0;
    pxo = 0; pyo = 0; pzo = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    @(negedge clk);

    send(tpch_pkg::CMD_TEST, 0, 0, 32'd100);
    send(tpch_pkg::CMD_TEST, 0, 0, 32'hffffffff);
    send(tpch_pkg::CMD_TEST, 0, 0, 32'd13108);
    send(tpch_pkg::CMD_APPEND, q16(-0.5), q16(-0.5), 0);
    send(tpch_pkg::CMD_APPEND, q16(0.5), q16(-0.5), 0);
    send(tpch_pkg::CMD_APPEND, q16(0.5), q16(0.5), 0);
    send(tpch_pkg::CMD_APPEND, q16(-0.5), q16(0.5), 0);
    send(tpch_pkg::CMD_TEST, q16(0.1), q16(0.2), 32'd13107);
    send(tpch_pkg::CMD_TEST, q16(0.7), q16(0.2), 32'd0);
    send(tpch_pkg::CMD_TEST, 32'h7fffffff, 32'h80000000, 32'd50);
    send(tpch_pkg::CMD_TEST, q16(0.5), q16(0.0), 32'd50);
    send(tpch_pkg::CMD_NONE, $urandom, $urandom, $urandom);
    send(tpch_pkg::CMD_TEST, 32'h80000000, 32'h7fffffff, 32'h7fffffff);
    for (int i = 0; i < 30; i++)
      send(tpch_pkg::CMD_APPEND, q16(0.5), q16(0.5 + i * 0.001), 0);
    send(tpch_pkg::CMD_TEST, q16(-0.2), q16(0.1), 32'd10);
    send(tpch_pkg::CMD_CLEAR, 0, 0, 0);
    send(tpch_pkg::CMD_APPEND, q16(0.1), q16(0.1), 0);
    send(tpch_pkg::CMD_APPEND, q16(0.105), q16(0.1), 0);
    send(tpch_pkg::CMD_APPEND, q16(0.1), q16(0.105), 0);
    send(tpch_pkg::CMD_TEST, q16(3.0), q16(3.0), 32'd10);

    set_pose(32'h7fffffff, 32'h80000000, 32'h80000000, 32'h80000000,
             32'h7fffffff, 32'hc0000000, 32'h40000000, 32'h7fffffff);
    load_polygon(32, 0.6, 0);
    send(tpch_pkg::CMD_APPEND, q16(9.0), q16(9.0), 0);
    for (int i = 0; i < 6; i++) send(tpch_pkg::CMD_TEST, $urandom, $urandom, $urandom);
    set_pose(0, 0, 0, 32'h40000000, 0, 0, 0, 0);
    load_polygon(4, 0.4, 0);
    send(tpch_pkg::CMD_TEST, 0, 0, 0);
    send(tpch_pkg::CMD_TEST, 0, 0, 32'd1);

    while (n_beats < 1850) begin
      case ($urandom_range(0, 4))
        0: begin
          ang_c = 1.0; ang_s = 0.0; pzoff = 0.0;
          set_pose(0, 0, 0, 32'h40000000, 0, 0, 0, 32'd13107);
        end
        1, 2: begin
          ang = ($urandom_range(0, 6283) / 1000.0) / 2.0;
          ang_c = $cos(2.0 * ang);
          ang_s = $sin(2.0 * ang);
          pzoff = 0.0;
          set_pose(q16($urandom_range(0, 10000) / 1000.0 - 5.0),
                   q16($urandom_range(0, 10000) / 1000.0 - 5.0),
                   q16($urandom_range(0, 2000) / 1000.0 - 1.0),
                   32'($rtoi($cos(ang) * 1073741824.0)), 0, 0,
                   32'($rtoi($sin(ang) * 1073741824.0)),
                   32'($urandom_range(3000, 40000)));
        end
        3: begin
          ang_c = 1.0; ang_s = 0.0; pzoff = 0.0;
          set_pose($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                   $urandom, $urandom);
        end
        default: begin
          ang_c = -1.0; ang_s = 0.0; pzoff = 0.0;
          set_pose(q16(1.5), q16(-0.75), q16(0.8), 0, 0, 0, 32'hc0000000,
                   32'($urandom_range(0, 1) ? 31'h7fffffff : 31'd0));
        end
      endcase
      for (int s = 0; s < 12 && n_beats < 1850; s++) begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 34) : $urandom_range(3, 8);
        rad = $urandom_range(50, 1500) / 1000.0;
        if ($urandom_range(0, 7) == 0) begin
          for (int i = 0; i < 3; i++)
            send(tpch_pkg::cmd_t'($urandom_range(0, 3)), $urandom, $urandom, $urandom);
        end
        load_polygon(n, rad, $urandom_range(0, 4) == 0);
        for (int t = $urandom_range(3, 10); t > 0; t--) begin
          if ($urandom_range(0, 9) == 0)
            send(tpch_pkg::CMD_TEST, $urandom, $urandom, $urandom);
          else probe(rad * 1.3);
        end
      end
    end

    drain();
    $display("covered %0d command beats, %0d test results, %0d register settings",
             n_beats, n_results, n_settings);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
